[rtl/core/ealf_pkg.sv]
package ealf_pkg;

   localparam int MAX_WIDTH    = 2048;
   localparam int MAX_HEIGHT   = 4096;
   localparam int MAX_CHANNELS = 4;
   localparam int STORE_DEPTH  = MAX_WIDTH * MAX_CHANNELS;

   localparam int ADDR_W     = $clog2(STORE_DEPTH);
   localparam int LEN_W      = ADDR_W + 1;
   localparam int SAMPLE_W   = 8;
   localparam int FILT_W     = 11;
   localparam int WIDTH_W    = 12;
   localparam int HEIGHT_W   = 13;
   localparam int ROW_W      = 12;
   localparam int CHAN_W     = 3;
   localparam int CHSEL_W    = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 13;

   localparam logic [CSR_IDX_W-1:0] REG_FRAME_WIDTH   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_FRAME_HEIGHT  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_CHANNEL_COUNT = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SIGNED_OUTPUT = 2'd3;

   localparam logic ACT_SAMPLE = 1'b0;
   localparam logic ACT_DRAIN  = 1'b1;

   localparam logic [WIDTH_W-1:0]  FRAME_WIDTH_RST   = 12'd640;
   localparam logic [HEIGHT_W-1:0] FRAME_HEIGHT_RST  = 13'd480;
   localparam logic [CHAN_W-1:0]   CHANNEL_COUNT_RST = 3'd3;

   localparam logic [WIDTH_W-1:0]  WIDTH_LIMIT   = WIDTH_W'(MAX_WIDTH);
   localparam logic [HEIGHT_W-1:0] HEIGHT_LIMIT  = HEIGHT_W'(MAX_HEIGHT);
   localparam logic [CHAN_W-1:0]   CHANNEL_LIMIT = CHAN_W'(MAX_CHANNELS);
   localparam logic [FILT_W:0]     BYTE_MAX      = 12'd255;

   typedef struct packed {
      logic                rd_en;
      logic [ADDR_W-1:0]   rd_addr;
      logic [ADDR_W-1:0]   east_addr;
      logic                mid_we;
      logic [ADDR_W-1:0]   mid_waddr;
      logic [SAMPLE_W-1:0] mid_wdata;
      logic                up_we;
      logic [ADDR_W-1:0]   up_waddr;
   } store_ctrl_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] center;
      logic [SAMPLE_W-1:0] east;
      logic [SAMPLE_W-1:0] north;
   } store_data_type;

endpackage

[rtl/core/ealf_req_if.sv]
interface ealf_req_if;
   import ealf_pkg::*;

   logic                valid;
   logic                ready;
   logic                action;
   logic [SAMPLE_W-1:0] sample;

   modport source (output valid, output action, output sample, input ready);
   modport sink (input valid, input action, input sample, output ready);

endinterface

[rtl/core/ealf_rsp_if.sv]
interface ealf_rsp_if;
   import ealf_pkg::*;

   logic                     valid;
   logic                     ready;
   logic signed [FILT_W-1:0] filtered;
   logic                     frame_end;

   modport source (output valid, output filtered, output frame_end, input ready);
   modport sink (input valid, input filtered, input frame_end, output ready);

endinterface

[rtl/core/ealf_line_store.sv]
module ealf_line_store (
   input  logic                    clock,
   input  ealf_pkg::store_ctrl_type ctrl,
   output ealf_pkg::store_data_type data
);
   import ealf_pkg::*;

   logic [SAMPLE_W-1:0] mid_mem [STORE_DEPTH];
   logic [SAMPLE_W-1:0] up_mem [STORE_DEPTH];

   logic [SAMPLE_W-1:0] center_ff;
   logic [SAMPLE_W-1:0] east_ff;
   logic [SAMPLE_W-1:0] north_ff;
   logic                fwd_ff;
   logic [SAMPLE_W-1:0] fwd_data_ff;

   // The middle store is read at the center and east positions; a write of the
   // current sample in the same cycle returns the old contents.
   always_ff @(posedge clock) begin
      if (ctrl.rd_en) begin
         center_ff <= mid_mem[ctrl.rd_addr];
         east_ff   <= mid_mem[ctrl.east_addr];
      end
      if (ctrl.mid_we) begin
         mid_mem[ctrl.mid_waddr] <= ctrl.mid_wdata;
      end
   end

   // The upper store takes the old center from the center register when the read
   // stage advances, so a read of the same entry in that cycle is served from the bypass register.
   always_ff @(posedge clock) begin
      if (ctrl.rd_en) begin
         north_ff    <= up_mem[ctrl.rd_addr];
         fwd_ff      <= ctrl.up_we && (ctrl.up_waddr == ctrl.rd_addr);
         fwd_data_ff <= center_ff;
      end
      if (ctrl.up_we) begin
         up_mem[ctrl.up_waddr] <= center_ff;
      end
   end

   assign data.center = center_ff;
   assign data.east   = east_ff;
   assign data.north  = fwd_ff ? fwd_data_ff : north_ff;

endmodule

[rtl/core/edge_aware_laplacian_filter.sv]
// Four-neighbor Laplacian filter over a raster stream of 8-bit samples with
// interleaved channels. Each word on req_ch carries an action and a sample.
// A sample word of the first row is only stored; a sample word of a later
// row yields one word on rsp_ch for the same position one row above. Once
// the last row is in, drain words yield the results of the last row, and
// frame_end marks the final one. Neighbors outside the frame are left out.
// Configuration is written through csr_we, csr_index and csr_wdata while the
// block is idle; every write restarts the frame at its first sample.
// The block takes one word per clock while rsp_ch does not stall. A result
// reaches rsp_ch through the read stage and the output register: the line
// store is read at the accepting edge and the output register loads when the
// read stage advances. When rsp_ch stalls, both hold their words and
// req_ch.ready drops while the read stage is full, until the output moves on.
// Reset restores the register defaults (640 x 480, three channels, byte
// mode) and the frame start; line store contents are not cleared and need
// no clearing, since each entry is written before its value is used.
module edge_aware_laplacian_filter (
   input  logic                               clock,
   input  logic                               reset,
   ealf_req_if.sink                           req_ch,
   ealf_rsp_if.source                         rsp_ch,
   input  logic                               csr_we,
   input  logic [ealf_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [ealf_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import ealf_pkg::*;

   logic [WIDTH_W-1:0]  frame_width_ff;
   logic [HEIGHT_W-1:0] frame_height_ff;
   logic [CHAN_W-1:0]   channel_count_ff;
   logic                signed_output_ff;

   logic [WIDTH_W-1:0]  width_eff;
   logic [HEIGHT_W-1:0] height_eff;
   logic [CHAN_W-1:0]   chan_eff;
   logic [LEN_W-1:0]    row_len;
   logic [LEN_W-1:0]    chan_ext;
   logic [CHSEL_W-1:0]  west_sel;

   logic [ADDR_W-1:0]   col_ff, col_in;
   logic [ROW_W-1:0]    row_ff, row_in;
   logic [ADDR_W-1:0]   drain_ff, drain_in;
   logic                complete_ff, complete_in;

   logic                accept;
   logic                is_drain;
   logic [ADDR_W-1:0]   pos;
   logic [LEN_W-1:0]    pos_ext;
   logic [LEN_W-1:0]    east_pos;
   logic [LEN_W-1:0]    next_pos;
   logic                at_row_end;
   logic                last_row;
   logic                sample_ok;
   logic                drain_ok;
   logic                produce;
   logic                has_north;

   logic                s1_valid_ff;
   logic                s1_adv;
   logic [ADDR_W-1:0]   s1_pos_ff;
   logic                s1_upd_ff;
   logic                s1_south_ff;
   logic [SAMPLE_W-1:0] s1_sample_ff;
   logic                s1_north_ff;
   logic                s1_west_ff;
   logic                s1_east_ff;
   logic                s1_end_ff;

   logic [SAMPLE_W-1:0] west_ff [MAX_CHANNELS];

   store_ctrl_type      store_ctrl;
   store_data_type      store_data;

   logic [2:0]          count;
   logic [FILT_W-1:0]   product;
   logic [FILT_W-1:0]   nsum;
   logic signed [FILT_W:0] diff;
   logic [FILT_W:0]     mag;
   logic [FILT_W-1:0]   filt;

   logic                out_valid_ff;
   logic signed [FILT_W-1:0] out_filt_ff;
   logic                out_end_ff;

   // Effective frame geometry with out-of-range settings clamped.
   always_comb begin
      if (frame_width_ff == '0) begin
         width_eff = WIDTH_W'(1);
      end else if (frame_width_ff > WIDTH_LIMIT) begin
         width_eff = WIDTH_LIMIT;
      end else begin
         width_eff = frame_width_ff;
      end
      if (frame_height_ff == '0) begin
         height_eff = HEIGHT_W'(1);
      end else if (frame_height_ff > HEIGHT_LIMIT) begin
         height_eff = HEIGHT_LIMIT;
      end else begin
         height_eff = frame_height_ff;
      end
      if (channel_count_ff == '0) begin
         chan_eff = CHAN_W'(1);
      end else if (channel_count_ff > CHANNEL_LIMIT) begin
         chan_eff = CHANNEL_LIMIT;
      end else begin
         chan_eff = channel_count_ff;
      end
   end

   assign row_len  = {2'b00, width_eff} * {{(LEN_W-CHAN_W){1'b0}}, chan_eff};
   assign chan_ext = {{(LEN_W-CHAN_W){1'b0}}, chan_eff};
   assign west_sel = CHSEL_W'(chan_eff - CHAN_W'(1));

   // Input stage: position decode and line store addressing.
   assign s1_adv       = s1_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !s1_valid_ff || s1_adv;
   assign accept       = req_ch.valid && req_ch.ready;
   assign is_drain     = (req_ch.action == ACT_DRAIN);

   assign pos        = is_drain ? drain_ff : col_ff;
   assign pos_ext    = {1'b0, pos};
   assign east_pos   = pos_ext + chan_ext;
   assign next_pos   = pos_ext + LEN_W'(1);
   assign at_row_end = (next_pos >= row_len);
   assign last_row   = (({1'b0, row_ff} + HEIGHT_W'(1)) >= height_eff);
   assign sample_ok  = !complete_ff && ({1'b0, col_ff} < row_len);
   assign drain_ok   = complete_ff && ({1'b0, drain_ff} < row_len);
   assign produce    = is_drain ? drain_ok : (sample_ok && (row_ff != '0));
   assign has_north  = is_drain ? (height_eff >= HEIGHT_W'(2)) : (row_ff >= ROW_W'(2));

   always_comb begin
      store_ctrl.rd_en     = accept && produce;
      store_ctrl.rd_addr   = pos;
      store_ctrl.east_addr = east_pos[ADDR_W-1:0];
      store_ctrl.mid_we    = accept && !is_drain && sample_ok;
      store_ctrl.mid_waddr = col_ff;
      store_ctrl.mid_wdata = req_ch.sample;
      store_ctrl.up_we     = s1_adv && s1_upd_ff;
      store_ctrl.up_waddr  = s1_pos_ff;
   end

   ealf_line_store u_line_store (
      .clock (clock),
      .ctrl  (store_ctrl),
      .data  (store_data)
   );

   // Raster position counters.
   always_comb begin
      col_in      = col_ff;
      row_in      = row_ff;
      drain_in    = drain_ff;
      complete_in = complete_ff;
      if (csr_we) begin
         col_in      = '0;
         row_in      = '0;
         drain_in    = '0;
         complete_in = 1'b0;
      end else if (accept && !is_drain && sample_ok) begin
         if (at_row_end) begin
            col_in = '0;
            if (last_row) begin
               complete_in = 1'b1;
               drain_in    = '0;
            end else begin
               row_in = row_ff + ROW_W'(1);
            end
         end else begin
            col_in = next_pos[ADDR_W-1:0];
         end
      end else if (accept && is_drain && drain_ok) begin
         if (at_row_end) begin
            col_in      = '0;
            row_in      = '0;
            drain_in    = '0;
            complete_in = 1'b0;
         end else begin
            drain_in = next_pos[ADDR_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         drain_ff    <= '0;
         complete_ff <= 1'b0;
      end else begin
         col_ff      <= col_in;
         row_ff      <= row_in;
         drain_ff    <= drain_in;
         complete_ff <= complete_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff   <= FRAME_WIDTH_RST;
         frame_height_ff  <= FRAME_HEIGHT_RST;
         channel_count_ff <= CHANNEL_COUNT_RST;
         signed_output_ff <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_FRAME_WIDTH:   frame_width_ff   <= csr_wdata[WIDTH_W-1:0];
            REG_FRAME_HEIGHT:  frame_height_ff  <= csr_wdata[HEIGHT_W-1:0];
            REG_CHANNEL_COUNT: channel_count_ff <= csr_wdata[CHAN_W-1:0];
            REG_SIGNED_OUTPUT: signed_output_ff <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   // Read stage: holds the word whose line store data is on the read port.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (accept && produce) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_adv) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && produce) begin
         s1_pos_ff    <= pos;
         s1_upd_ff    <= !is_drain;
         s1_south_ff  <= !is_drain;
         s1_sample_ff <= req_ch.sample;
         s1_north_ff  <= has_north;
         s1_west_ff   <= (pos_ext >= chan_ext);
         s1_east_ff   <= (east_pos < row_len);
         s1_end_ff    <= is_drain && at_row_end;
      end
   end

   // Centers of the most recent positions supply the west neighbor.
   always_ff @(posedge clock) begin
      if (s1_adv) begin
         west_ff[0] <= store_data.center;
         for (int k = 1; k < MAX_CHANNELS; k++) begin
            west_ff[k] <= west_ff[k-1];
         end
      end
   end

   always_comb begin
      count = {2'b00, s1_south_ff} + {2'b00, s1_north_ff}
            + {2'b00, s1_west_ff} + {2'b00, s1_east_ff};
      product = {8'b0, count} * {3'b000, store_data.center};
      nsum = (s1_south_ff ? {3'b000, s1_sample_ff} : FILT_W'(0))
           + (s1_north_ff ? {3'b000, store_data.north} : FILT_W'(0))
           + (s1_west_ff ? {3'b000, west_ff[west_sel]} : FILT_W'(0))
           + (s1_east_ff ? {3'b000, store_data.east} : FILT_W'(0));
      diff = $signed({1'b0, product}) - $signed({1'b0, nsum});
      mag  = diff[FILT_W] ? 12'(-diff) : 12'(diff);
      if (signed_output_ff) begin
         filt = diff[FILT_W-1:0];
      end else if (mag > BYTE_MAX) begin
         filt = BYTE_MAX[FILT_W-1:0];
      end else begin
         filt = mag[FILT_W-1:0];
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (s1_adv) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         out_filt_ff <= $signed(filt);
         out_end_ff  <= s1_end_ff;
      end
   end

   assign rsp_ch.valid     = out_valid_ff;
   assign rsp_ch.filtered  = out_filt_ff;
   assign rsp_ch.frame_end = out_end_ff;

endmodule
